### sv/prdve_pkg.sv
// Shared types, constants and saturation helper for the delta PageRank vertex engine.
`timescale 1ns / 1ps

package prdve_pkg;

  localparam int VERTICES_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 32;

  localparam int VAL_W  = 36;
  localparam int VTX_W  = 10;
  localparam int DEG_W  = 16;
  localparam int CFG_W  = 32;
  localparam int FUNC_W = 2;
  localparam int CIDX_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_APPLY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [CIDX_W-1:0] REG_DAMPING = 2'd0;
  localparam logic [CIDX_W-1:0] REG_REL_TOL = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INV_N   = 2'd2;

  localparam logic [CFG_W-1:0] DAMPING_RST = 32'd3650722202;
  localparam logic [CFG_W-1:0] REL_TOL_RST = 32'd42949673;
  localparam logic [CFG_W-1:0] INV_N_RST   = 32'd4194304;

  localparam int MUL_STEPS = CFG_W + 1;
  localparam int DIV_STEPS = VAL_W;
  localparam int CNT_W     = 6;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 36'sh7_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 36'sh8_0000_0000;

  typedef struct packed {
    logic                    active;
    logic [DEG_W-1:0]        degree;
    logic signed [VAL_W-1:0] sum;
    logic signed [VAL_W-1:0] delta;
    logic signed [VAL_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [VAL_W-1:0] sat36(input logic signed [VAL_W+1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 38'(VAL_MAX)) begin
      r = VAL_MAX;
    end else if (v < 38'(VAL_MIN)) begin
      r = VAL_MIN;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/prdve_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module prdve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### sv/pagerank_delta_vertex_engine.sv
// Top level of the delta PageRank vertex engine with its sequencer and shared arithmetic.
//
//   Channel   Direction  Handshake                  Payload
//   command   in         start_i, busy_o            func, vertices, degree, first_round
//   result    out        done_o (one-cycle strobe)  vertex, flags, score, delta
//   config    in         cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// An item occupies the engine from acceptance until its result strobe. Push divides the
// source delta by its degree in the restoring divider (36 steps), skipped for an inactive
// source; apply runs the bit-serial multiplier (33 steps) twice in a later round and
// three in the first. Push reads the source, then the target; unused writes no entry.
// Reset is asynchronous and clears only the sequencer and config registers.
// The receiver cannot stall; configuration writes are always taken.
`timescale 1ns / 1ps

module pagerank_delta_vertex_engine
  import prdve_pkg::*;
#(
  parameter int VERTICES  = VERTICES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [FUNC_W-1:0]       func_i,
  input  logic [VTX_W-1:0]        target_vertex_i,
  input  logic [VTX_W-1:0]        source_vertex_i,
  input  logic [DEG_W-1:0]        out_degree_i,
  input  logic                    first_round_i,
  output logic                    done_o,
  output logic [VTX_W-1:0]        result_vertex_o,
  output logic                    stays_active_o,
  output logic                    first_touch_o,
  output logic signed [VAL_W-1:0] score_out_o,
  output logic signed [VAL_W-1:0] delta_out_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CIDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam int AW  = $clog2(VERTICES);
  localparam int SHL = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 0;
  localparam int SHR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
  localparam logic [48:0] RND = (49'd1 << SHR) >> 1;
  localparam int ACC_W = VAL_W + MUL_STEPS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DST  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_PADD = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_A1   = 4'd7;
  localparam logic [3:0] S_A2   = 4'd8;
  localparam logic [3:0] S_M3   = 4'd9;
  localparam logic [3:0] S_LATE = 4'd10;
  localparam logic [3:0] S_CMP  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  function automatic logic [AW-1:0] vidx(input logic [VTX_W-1:0] v);
    logic [20:0] w;
    w = 21'(v) % 21'(VERTICES);
    return w[AW-1:0];
  endfunction

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic       done_q, done_d;
  logic [CFG_W-1:0] damp_q, tol_q, invn_q;

  logic [FUNC_W-1:0] func_q, func_d;
  logic [VTX_W-1:0]  tgt_q, tgt_d;
  logic              first_q, first_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [VAL_W-1:0] score_q, score_d, delta_q, delta_d, sum_q, sum_d;
  logic [DEG_W-1:0]  deg_q, deg_d, dvs_q, dvs_d;
  logic              act_q, act_d, go_q, go_d, touch_q, touch_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [VAL_W-1:0]  mag_q, mag_d;
  logic [MUL_STEPS-1:0] mpl_q, mpl_d;
  logic              neg_q, neg_d;
  logic [DEG_W-1:0]  rem_q, rem_d;
  logic signed [VAL_W:0] t1_q, t1_d;

  logic [VTX_W-1:0]  rv_q, rv_d;
  logic              ra_q, ra_d, rt_q, rt_d;
  logic signed [VAL_W-1:0] rs_q, rs_d, rd_q, rd_d;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  entry_t            ram_wdata, ram_rdata;

  logic [48:0]       ov_wide;
  logic signed [VAL_W-1:0] inv_o;
  logic [ACC_W-1:0]  mul_rnd;
  logic [VAL_W:0]    mul_mag;
  logic signed [VAL_W:0] mul_res, div_res;
  logic              mul_go;
  logic [MUL_STEPS-1:0] mul_coef;
  logic signed [VAL_W-1:0] mul_val;
  logic [DEG_W:0]    div_t;
  logic              div_ge;
  logic signed [VAL_W+1:0] abs_delta;

  prdve_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(VERTICES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    ov_wide = ((49'(invn_q) << SHL) + RND) >> SHR;
    inv_o   = (ov_wide > 49'(VAL_MAX)) ? VAL_MAX : ov_wide[VAL_W-1:0];
    mul_rnd = acc_q + (ACC_W'(1) << (CFG_W - 1));
    mul_mag = mul_rnd[ACC_W-1:CFG_W];
    mul_res = neg_q ? -$signed(mul_mag) : $signed(mul_mag);
    div_res = neg_q ? -$signed({1'b0, acc_q[VAL_W-1:0]}) : $signed({1'b0, acc_q[VAL_W-1:0]});
    div_t   = {rem_q, acc_q[VAL_W-1]};
    div_ge  = div_t >= {1'b0, dvs_q};
    abs_delta = (delta_q < 0) ? -(38'(delta_q)) : 38'(delta_q);
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    done_d  = 1'b0;
    func_d  = func_q;
    tgt_d   = tgt_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    score_d = score_q;
    delta_d = delta_q;
    sum_d   = sum_q;
    deg_d   = deg_q;
    act_d   = act_q;
    dvs_d   = dvs_q;
    go_d    = go_q;
    touch_d = touch_q;
    acc_d   = acc_q;
    mag_d   = mag_q;
    mpl_d   = mpl_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    t1_d    = t1_q;
    rv_d    = rv_q;
    ra_d    = ra_q;
    rt_d    = rt_q;
    rs_d    = rs_q;
    rd_d    = rd_q;
    ram_we  = 1'b0;
    ram_addr = vidx(tgt_q);
    ram_wdata = '{active: act_q, degree: deg_q, sum: sum_q, delta: delta_q, score: score_q};
    mul_go   = 1'b0;
    mul_coef = {1'b0, damp_q};
    mul_val  = sum_q;

    case (state_q)
      S_IDLE: begin
        ram_addr = (func_i == FUNC_PUSH) ? vidx(source_vertex_i) : vidx(target_vertex_i);
        if (start_i) begin
          func_d  = func_i;
          tgt_d   = target_vertex_i;
          first_d = first_round_i;
          if (func_i == FUNC_INIT) begin
            score_d = '0;
            delta_d = inv_o;
            sum_d   = '0;
            deg_d   = out_degree_i;
            act_d   = 1'b1;
            touch_d = 1'b0;
            state_d = S_FIN;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (func_q == FUNC_PUSH) begin
          neg_d   = ram_rdata.delta < 0;
          mag_d   = (ram_rdata.delta < 0) ? VAL_W'(-ram_rdata.delta) : VAL_W'(ram_rdata.delta);
          dvs_d   = ram_rdata.degree;
          go_d    = ram_rdata.active && (ram_rdata.degree != '0);
          state_d = S_DST;
        end else begin
          score_d = ram_rdata.score;
          delta_d = ram_rdata.delta;
          sum_d   = ram_rdata.sum;
          deg_d   = ram_rdata.degree;
          act_d   = ram_rdata.active;
          touch_d = 1'b0;
          if (func_q == FUNC_UNUSED) begin
            act_d   = 1'b0;
            state_d = S_FIN;
          end else begin
            mul_go   = 1'b1;
            mul_coef = {1'b0, damp_q};
            mul_val  = ram_rdata.sum;
            ret_d    = first_q ? S_M2 : S_LATE;
            state_d  = S_MUL;
          end
        end
      end
      S_DST: begin
        score_d = ram_rdata.score;
        delta_d = ram_rdata.delta;
        sum_d   = ram_rdata.sum;
        deg_d   = ram_rdata.degree;
        act_d   = ram_rdata.active;
        touch_d = ram_rdata.sum == '0;
        if (go_q) begin
          acc_d   = ACC_W'(mag_q);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        rem_d = div_ge ? DEG_W'(div_t - {1'b0, dvs_q}) : div_t[DEG_W-1:0];
        acc_d = ACC_W'({acc_q[VAL_W-2:0], div_ge});
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_PADD;
        end
      end
      S_PADD: begin
        sum_d   = sat36(38'(sum_q) + 38'(div_res));
        state_d = S_FIN;
      end
      S_MUL: begin
        acc_d = (acc_q << 1) + (mpl_q[MUL_STEPS-1] ? ACC_W'(mag_q) : '0);
        mpl_d = mpl_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = ret_q;
        end
      end
      S_M2: begin
        t1_d     = mul_res;
        mul_go   = 1'b1;
        mul_coef = (MUL_STEPS'(1) << CFG_W) - {1'b0, damp_q};
        mul_val  = inv_o;
        ret_d    = S_A1;
        state_d  = S_MUL;
      end
      S_A1: begin
        delta_d = sat36(38'(t1_q) + 38'(mul_res));
        state_d = S_A2;
      end
      S_A2: begin
        score_d = sat36(38'(score_q) + 38'(delta_q));
        delta_d = sat36(38'(delta_q) - 38'(inv_o));
        state_d = S_M3;
      end
      S_LATE: begin
        delta_d = sat36(38'(mul_res));
        state_d = S_M3;
      end
      S_M3: begin
        mul_go   = 1'b1;
        mul_coef = {1'b0, tol_q};
        mul_val  = score_q;
        ret_d    = S_CMP;
        state_d  = S_MUL;
      end
      S_CMP: begin
        act_d = abs_delta > 38'(mul_res);
        if (!first_q && (abs_delta > 38'(mul_res))) begin
          score_d = sat36(38'(score_q) + 38'(delta_q));
        end
        sum_d   = '0;
        state_d = S_FIN;
      end
      S_FIN: begin
        ram_we  = func_q != FUNC_UNUSED;
        rv_d    = tgt_q;
        ra_d    = ((func_q == FUNC_INIT) || (func_q == FUNC_APPLY)) ? act_q : 1'b0;
        rt_d    = (func_q == FUNC_PUSH) ? touch_q : 1'b0;
        rs_d    = score_q;
        rd_d    = delta_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (mul_go) begin
      neg_d = mul_val < 0;
      mag_d = (mul_val < 0) ? VAL_W'(-mul_val) : VAL_W'(mul_val);
      mpl_d = mul_coef;
      acc_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      done_q  <= 1'b0;
      damp_q  <= DAMPING_RST;
      tol_q   <= REL_TOL_RST;
      invn_q  <= INV_N_RST;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_DAMPING: damp_q <= cfg_data_i;
          REG_REL_TOL: tol_q  <= cfg_data_i;
          REG_INV_N:   invn_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    tgt_q   <= tgt_d;
    first_q <= first_d;
    cnt_q   <= cnt_d;
    score_q <= score_d;
    delta_q <= delta_d;
    sum_q   <= sum_d;
    deg_q   <= deg_d;
    act_q   <= act_d;
    dvs_q   <= dvs_d;
    go_q    <= go_d;
    touch_q <= touch_d;
    acc_q   <= acc_d;
    mag_q   <= mag_d;
    mpl_q   <= mpl_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    t1_q    <= t1_d;
    rv_q    <= rv_d;
    ra_q    <= ra_d;
    rt_q    <= rt_d;
    rs_q    <= rs_d;
    rd_q    <= rd_d;
  end

  assign busy_o          = state_q != S_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign result_vertex_o = rv_q;
  assign stays_active_o  = ra_q;
  assign first_touch_o   = rt_q;
  assign score_out_o     = rs_q;
  assign delta_out_o     = rd_q;

endmodule

### sv/prdve_checker.sv
// Port-level checker for the delta PageRank vertex engine and its bind.
`timescale 1ns / 1ps

module prdve_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic stays_active_o,
  input logic first_touch_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o)) else $error("accepted item did not occupy the engine");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_busy_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i)) else $error("engine became busy without an item");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(stays_active_o && first_touch_o)) else $error("active and first-touch both set");

endmodule

bind pagerank_delta_vertex_engine prdve_checker u_prdve_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .stays_active_o(stays_active_o),
  .first_touch_o (first_touch_o)
);
